/* rtl/separable_box_filter_macros.svh */
// Assertion macros for the separable box filter checker.
// Used by sbf_checker.sv only; needs clk and rst in the including scope.
`ifndef SEPARABLE_BOX_FILTER_MACROS_SVH
`define SEPARABLE_BOX_FILTER_MACROS_SVH

// Property checked outside reset.
`define SBF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Property checked on every edge, reset included.
`define SBF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: check failed");

`endif

/* rtl/sbf_pkg.sv */
// Shared types and constants for the separable box filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sbf_pkg;

  // Configuration port widths and register indexes.
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 13;
  localparam logic [CFG_IW-1:0] REG_KERNEL_SIZE  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 2'd2;
  localparam logic [CFG_IW-1:0] REG_COLOR_MODE   = 2'd3;

  // Field widths fixed by the register map.
  localparam int KW  = 4;
  localparam int WFW = 11;
  localparam int HFW = 13;
  localparam int RW_ROW = 14;

  // Input beat commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_ch0;
    logic [7:0] in_ch1;
    logic [7:0] in_ch2;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic       frame_end;
  } pix_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_MULH,
    S_HV,
    S_UPD,
    S_MULV,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic shift;
    logic acc_start;
    logic acc_step;
    logic mul_h;
    logic hv_load;
    logic upd;
    logic mul_v;
    logic out_load;
    logic step;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_done;
    logic q_valid;
    logic acc_last;
    logic o_valid;
    logic out_busy;
  } ctl_stat_t;

endpackage

/* rtl/sbf_controller.sv */
// Sequencing state machine for the separable box filter.
// Depends on sbf_pkg; drives sbf_datapath through ctl_cmd_t.
`timescale 1ns / 1ps

module sbf_controller import sbf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_cmd,
  input  ctl_stat_t stat,
  output ctl_cmd_t  ctl,
  output logic      in_stall
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // New beats are taken only between items.
  assign in_stall = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        // A flush before the last pixel is dropped without effect.
        if (in_valid && !(!stat.in_done && in_cmd == CMD_FLUSH)) begin
          ctl.shift = 1'b1;
          if (stat.q_valid) begin
            ctl.acc_start = 1'b1;
            state_next    = S_ACC;
          end else begin
            ctl.step = 1'b1;
          end
        end
      end
      S_ACC: begin
        ctl.acc_step = 1'b1;
        if (stat.acc_last) begin
          state_next = S_MULH;
        end
      end
      S_MULH: begin
        ctl.mul_h  = 1'b1;
        state_next = S_HV;
      end
      S_HV: begin
        ctl.hv_load = 1'b1;
        state_next  = S_UPD;
      end
      S_UPD: begin
        ctl.upd = 1'b1;
        if (stat.o_valid) begin
          state_next = S_MULV;
        end else begin
          ctl.step   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MULV: begin
        ctl.mul_v  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          ctl.out_load = 1'b1;
          ctl.step     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sbf_datapath.sv */
// Datapath of the separable box filter: registers, window, line store,
// column sums, reciprocal divider and output register. Depends on sbf_pkg.
`timescale 1ns / 1ps

module sbf_datapath import sbf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  pix_in_t           in_data,
  input  ctl_cmd_t          ctl,
  output ctl_stat_t         stat,
  output logic              out_valid,
  output pix_out_t          out_data,
  input  logic              out_stall
);

  localparam int KMAX_ODD = (MAX_KERNEL - 1) | 1;
  localparam int KIW      = $clog2(KMAX_ODD);
  localparam int SW       = $clog2(KMAX_ODD * 255 + 1);
  localparam int RS       = SW + KW;
  localparam int RW       = RS + 1;
  localparam int PW       = SW + RW;
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int LD       = KMAX_ODD * MAX_WIDTH;
  localparam int LAW      = $clog2(LD);

  typedef logic [2:0][7:0]    pix3_t;
  typedef logic [2:0][SW-1:0] sum3_t;

  // Quotient from the reciprocal product, clamped to a byte.
  function automatic logic [7:0] clamp_q(input logic [PW-1:0] p);
    logic [PW-RS-1:0] q;
    q = p[PW-1:RS];
    return (q > (PW-RS)'(255)) ? 8'hFF : q[7:0];
  endfunction

  logic [KW-1:0]     cfg_k;
  logic [WFW-1:0]    cfg_w;
  logic [HFW-1:0]    cfg_h;
  logic              cfg_color;
  logic [KW-1:0]     k_or;
  logic [KW-1:0]     k_eff;
  logic [KW-1:0]     b_eff;
  logic [WFW-1:0]    w_one;
  logic [WFW-1:0]    w_eff;
  logic [HFW-1:0]    h_eff;

  logic [CW-1:0]     in_col;
  logic [RW_ROW-1:0] in_row;
  logic [CW-1:0]     qcol;
  logic [RW_ROW-1:0] qrow;
  logic [KIW-1:0]    srow;
  logic [KIW-1:0]    lead;
  logic [KIW-1:0]    idx;
  logic              frame_last;
  logic              incl;

  pix3_t             win [KMAX_ODD];
  pix3_t             smp;
  sum3_t             acc;
  logic [PW-1:0]     prod [3];
  pix3_t             hv;
  sum3_t             cs_new;
  sum3_t             cs_calc;
  logic [RW-1:0]     recip_tab [1 << KW];
  logic [RW-1:0]     recip;

  sum3_t             cs_mem [MAX_WIDTH];
  pix3_t             ls_mem [LD];
  sum3_t             cs_rd;
  pix3_t             ls_rd;
  logic [LAW-1:0]    ls_addr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_k     <= KW'(5);
      cfg_w     <= WFW'(640);
      cfg_h     <= HFW'(480);
      cfg_color <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KERNEL_SIZE:  cfg_k     <= cfg_data[KW-1:0];
        REG_IMAGE_WIDTH:  cfg_w     <= cfg_data[WFW-1:0];
        REG_IMAGE_HEIGHT: cfg_h     <= cfg_data[HFW-1:0];
        REG_COLOR_MODE:   cfg_color <= cfg_data[0];
        default:          cfg_k     <= cfg_k;
      endcase
    end
  end

  // Effective geometry: odd kernel within range, non-zero sizes.
  always_comb begin
    k_or  = cfg_k | KW'(1);
    k_eff = (32'(k_or) > KMAX_ODD) ? KW'(KMAX_ODD) : k_or;
    b_eff = k_eff >> 1;
    w_one = (cfg_w == '0) ? WFW'(1) : cfg_w;
    w_eff = (32'(w_one) > MAX_WIDTH) ? WFW'(MAX_WIDTH) : w_one;
    h_eff = (cfg_h == '0) ? HFW'(1) : cfg_h;
  end

  // Status towards the controller.
  always_comb begin
    frame_last = (32'(qrow) == 32'(h_eff) + 32'(b_eff) - 1) &&
                 (32'(qcol) == 32'(w_eff) - 1) && (32'(qrow) >= 32'(b_eff));
    stat.in_done  = (32'(in_row) >= 32'(h_eff));
    stat.q_valid  = (32'(lead) == 32'(b_eff));
    stat.acc_last = (32'(idx) == 32'(k_eff) - 1);
    stat.o_valid  = (32'(qrow) >= 32'(b_eff));
    stat.out_busy = out_valid && out_stall;
  end

  // Stream positions: input step, centre pixel and line store row.
  always_ff @(posedge clk) begin
    if (rst || cfg_valid || (ctl.step && frame_last)) begin
      in_col <= '0;
      in_row <= '0;
      qcol   <= '0;
      qrow   <= '0;
      srow   <= '0;
      lead   <= '0;
    end else if (ctl.step) begin
      if (32'(in_col) + 1 == 32'(w_eff)) begin
        in_col <= '0;
        in_row <= in_row + RW_ROW'(1);
      end else begin
        in_col <= in_col + CW'(1);
      end
      if (stat.q_valid) begin
        if (32'(qcol) + 1 == 32'(w_eff)) begin
          qcol <= '0;
          qrow <= qrow + RW_ROW'(1);
          srow <= (32'(srow) + 1 == 32'(k_eff)) ? '0 : srow + KIW'(1);
        end else begin
          qcol <= qcol + CW'(1);
        end
      end else begin
        lead <= lead + KIW'(1);
      end
    end
  end

  // Sample window; samples past the last pixel and gray-mode extras are zero.
  always_comb begin
    smp = '0;
    if (!stat.in_done) begin
      smp[0] = in_data.in_ch0;
      if (cfg_color) begin
        smp[1] = in_data.in_ch1;
        smp[2] = in_data.in_ch2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win[0] <= smp;
      for (int j = 1; j < KMAX_ODD; j++) begin
        win[j] <= win[j-1];
      end
    end
  end

  // Horizontal sum, one window tap per cycle, restricted to the centre's row.
  assign incl = (32'(qrow) < 32'(h_eff)) &&
                (32'(qcol) + 32'(b_eff) >= 32'(idx)) &&
                (32'(qcol) + 32'(b_eff) - 32'(idx) <= 32'(w_eff) - 1);

  always_ff @(posedge clk) begin
    if (ctl.acc_start) begin
      idx <= '0;
      acc <= '0;
    end else if (ctl.acc_step) begin
      idx <= idx + KIW'(1);
      if (incl) begin
        for (int c = 0; c < 3; c++) begin
          acc[c] <= acc[c] + SW'(win[idx][c]);
        end
      end
    end
  end

  // Reciprocal table: ceil(2^RS / k), exact for every sum below 2^SW.
  for (genvar j = 0; j < (1 << KW); j++) begin : g_recip
    localparam int R = ((1 << RS) + j - 1) / ((j == 0) ? 1 : j);
    assign recip_tab[j] = RW'(R);
  end
  assign recip = recip_tab[k_eff];

  // Shared multiplier for the horizontal and the vertical divide.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (ctl.mul_h) begin
        prod[c] <= PW'(acc[c]) * PW'(recip);
      end else if (ctl.mul_v) begin
        prod[c] <= PW'(cs_new[c]) * PW'(recip);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hv_load) begin
      for (int c = 0; c < 3; c++) begin
        hv[c] <= clamp_q(prod[c]);
      end
    end
  end

  // Line store and column sum memories with registered reads.
  always_comb begin
    ls_addr = LAW'(32'(srow) * MAX_WIDTH + 32'(qcol));
  end

  always_ff @(posedge clk) begin
    cs_rd <= cs_mem[qcol];
    ls_rd <= ls_mem[ls_addr];
    if (ctl.upd) begin
      cs_mem[qcol]    <= cs_calc;
      ls_mem[ls_addr] <= hv;
    end
  end

  // Running column sum over the last k horizontal results.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (qrow == '0) begin
        cs_calc[c] = SW'(hv[c]);
      end else if (32'(qrow) < 32'(k_eff)) begin
        cs_calc[c] = cs_rd[c] + SW'(hv[c]);
      end else begin
        cs_calc[c] = cs_rd[c] - SW'(ls_rd[c]) + SW'(hv[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      cs_new <= cs_calc;
    end
  end

  // Output register; holds its beat while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data.out_ch0   <= clamp_q(prod[0]);
      out_data.out_ch1   <= clamp_q(prod[1]);
      out_data.out_ch2   <= clamp_q(prod[2]);
      out_data.frame_end <= frame_last;
    end
  end

endmodule

/* rtl/separable_box_filter.sv */
// An input beat is taken only in the idle state; the input stalls while an item is worked on,
// whether it gives a result or only moves the column sums, but not while the window is filling.
// The k taps are summed one per cycle, by one accumulator per channel.
// Reset is synchronous: registers return to k = 5, 640 x 480, colour; positions cleared.
// Line store and column sums need no clearing; any register write restarts the image.
`timescale 1ns / 1ps

module separable_box_filter import sbf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pix_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pix_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  // Register writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  sbf_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .stat     (stat),
    .ctl      (ctl),
    .in_stall (in_stall)
  );

  sbf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

/* rtl/sbf_checker.sv */
// Port-level checks for the separable box filter, bound to the top level.
// Depends on sbf_pkg and separable_box_filter_macros.svh.
`timescale 1ns / 1ps
`include "separable_box_filter_macros.svh"

module sbf_checker import sbf_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input pix_out_t out_data
);

  // Reset leaves no result beat pending.
  `SBF_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

  // A stalled result beat stays and holds its payload.
  `SBF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))

  // A result is never loaded on the edge that takes an input beat.
  `SBF_ASSERT(a_no_load_on_accept, in_valid && !in_stall |=> !$rose(out_valid))

endmodule

bind separable_box_filter sbf_checker u_sbf_checker (.*);
